// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define SMAO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SMAO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/smao_pkg.sv
// types, constants and helpers of the swerve module angle optimiser
package smao_pkg;

    localparam int WHEEL_COUNT = 3;

    // angles in 1/64 degree
    localparam logic signed [17:0] DEG90  = 18'sd5760;
    localparam logic signed [17:0] DEG180 = 18'sd11520;
    localparam logic signed [17:0] DEG360 = 18'sd23040;
    localparam logic signed [17:0] DEG270 = DEG360 - DEG90;
    localparam logic signed [17:0] DEG450 = DEG360 + DEG90;

    // x mod 45 by reciprocal: floor(z / 45) = (z * 5826) >> 18 for z < 4100
    localparam logic [12:0] MOD45_RECIP = 13'd5826;
    localparam int          MOD45_SHIFT = 18;
    localparam logic [12:0] MOD45_DIV   = 13'd45;

    localparam logic [31:0] APC_RESET = 32'd1310720;
    localparam logic [31:0] CPA_RESET = 32'd838861;
    localparam logic [31:0] EPS_RESET = 32'd87615;

    typedef enum logic [1:0] {
        REG_STEER_POL        = 2'd0,
        REG_ANGLE_PER_COUNT  = 2'd1,
        REG_COUNTS_PER_ANGLE = 2'd2,
        REG_ERPM_PER_SPEED   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]          wheel;
        logic signed [15:0]  speed;
        logic signed [15:0]  heading;
        logic signed [31:0]  count;
    } in_item_t;

    // fields that ride along the whole pipe
    typedef struct packed {
        logic [1:0]          wheel;
        logic                rej;
        logic signed [15:0]  heading;
        logic                spd_neg;
        logic [31:0]         em;
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        cnt_neg;
        logic [38:0] am;
    } front_s1_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        neg_a;
        logic [38:0] am;
        logic [12:0] z;
    } front_out_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        neg_a;
        logic [38:0] am;
        logic [12:0] z;
        logic [7:0]  q45;
    } wrap_s3_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               neg_a;
        logic [38:0]        am;
        logic signed [15:0] wrapped;
    } wrap_out_t;

    typedef struct packed {
        cmd_t               cmd;
        logic               neg_a;
        logic [38:0]        am;
        logic signed [17:0] delta;
        logic               rev;
    } turn_s5_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        rev;
        logic        f_neg;
        logic [39:0] fm;
    } turn_out_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        rev;
        logic        f_neg;
        logic [55:0] qhi;
        logic [31:0] qlo;
    } scale_s7_t;

    typedef struct packed {
        logic [1:0]         wheel;
        logic signed [31:0] enc;
        logic signed [31:0] erpm;
        logic               rev;
        logic               rej;
    } out_item_t;

    // sign and magnitude to saturated 32 bit two's complement
    function automatic logic [31:0] sat32(input logic neg, input logic [56:0] m);
        logic [31:0] res;
        if (neg) begin
            if (m > 57'h0_8000_0000) begin
                res = 32'h8000_0000;
            end
            else begin
                res = ~m[31:0] + 32'd1;
            end
        end
        else begin
            if (m > 57'h0_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end
            else begin
                res = m[31:0];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/smao_front.sv
// front stages: encoder and speed scaling, then folding the heading for mod 45
module smao_front
    import smao_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        steer_pol,
    input  logic [31:0] angle_per_count,
    input  logic [31:0] erpm_per_speed,
    input  logic        up_valid,
    input  in_item_t    up_data,
    output logic        up_stall,
    output logic        dn_valid,
    output front_out_t  dn_data,
    input  logic        dn_stall
);

    logic        s1_valid_reg;
    front_s1_t   s1_reg;
    front_s1_t   s1_next;
    logic        s1_stall;
    logic        s2_valid_reg;
    front_out_t  s2_reg;
    front_out_t  s2_next;
    logic        s2_stall;

    logic [31:0] cnt_mag;
    logic [15:0] spd_mag;
    logic [63:0] cnt_prod;
    logic [47:0] spd_prod;
    logic [29:0] fold_x;
    logic [13:0] fold_y;
    logic [12:0] fold_z;

    assign s1_stall = s1_valid_reg & s2_stall;
    assign s2_stall = s2_valid_reg & dn_stall;
    assign up_stall = s1_stall;

    // stage 1: the two scaling multiplies
    always_comb
    begin
        cnt_mag  = up_data.count[31] ? 32'(-up_data.count) : 32'(up_data.count);
        spd_mag  = up_data.speed[15] ? 16'(-up_data.speed) : 16'(up_data.speed);
        cnt_prod = 64'(cnt_mag) * 64'(angle_per_count);
        spd_prod = 48'(spd_mag) * 48'(erpm_per_speed);

        s1_next.cmd.wheel   = up_data.wheel;
        s1_next.cmd.rej     = (up_data.wheel >= 2'(WHEEL_COUNT));
        s1_next.cmd.heading = up_data.heading;
        s1_next.cmd.spd_neg = up_data.speed[15];
        s1_next.cmd.em      = spd_prod[47:16];
        s1_next.cnt_neg     = up_data.count[31];
        s1_next.am          = cnt_prod[62:24];
    end

    // stage 2: 23040 = 512 * 45 and 2^12 = 1 mod 45, so fold 12 bit chunks
    always_comb
    begin
        fold_x = s1_reg.am[38:9];
        fold_y = 14'(fold_x[11:0]) + 14'(fold_x[23:12]) + 14'(fold_x[29:24]);
        fold_z = 13'(fold_y[11:0]) + 13'(fold_y[13:12]);

        s2_next.cmd   = s1_reg.cmd;
        s2_next.neg_a = s1_reg.cnt_neg ^ steer_pol;
        s2_next.am    = s1_reg.am;
        s2_next.z     = fold_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_stall)
            begin
                s1_valid_reg <= up_valid;
            end
            if (!s2_stall)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (!s2_stall && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

endmodule

// File: rtl/core/smao_wrap.sv
// wrap stages: heading mod 360 degrees, moved into (-180, 180]
module smao_wrap
    import smao_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    input  front_out_t  up_data,
    output logic        up_stall,
    output logic        dn_valid,
    output wrap_out_t   dn_data,
    input  logic        dn_stall
);

    logic        s3_valid_reg;
    wrap_s3_t    s3_reg;
    wrap_s3_t    s3_next;
    logic        s3_stall;
    logic        s4_valid_reg;
    wrap_out_t   s4_reg;
    wrap_out_t   s4_next;
    logic        s4_stall;

    logic [25:0]        recip_prod;
    logic [12:0]        mul45;
    logic [12:0]        rem45;
    logic [14:0]        rem_mag;
    logic signed [15:0] rem_signed;
    logic signed [15:0] wrapped;

    assign s3_stall = s3_valid_reg & s4_stall;
    assign s4_stall = s4_valid_reg & dn_stall;
    assign up_stall = s3_stall;

    // stage 3: quotient by 45
    always_comb
    begin
        recip_prod    = 26'(up_data.z) * 26'(MOD45_RECIP);
        s3_next.cmd   = up_data.cmd;
        s3_next.neg_a = up_data.neg_a;
        s3_next.am    = up_data.am;
        s3_next.z     = up_data.z;
        s3_next.q45   = recip_prod[MOD45_SHIFT +: 8];
    end

    // stage 4: remainder, sign of the dividend, then into half-open range
    always_comb
    begin
        mul45      = 13'(s3_reg.q45) * MOD45_DIV;
        rem45      = s3_reg.z - mul45;
        rem_mag    = {rem45[5:0], s3_reg.am[8:0]};
        rem_signed = s3_reg.neg_a ? -$signed({1'b0, rem_mag}) : $signed({1'b0, rem_mag});
        if (rem_signed > 16'(DEG180))
        begin
            wrapped = rem_signed - 16'(DEG360);
        end
        else if (rem_signed <= -16'(DEG180))
        begin
            wrapped = rem_signed + 16'(DEG360);
        end
        else
        begin
            wrapped = rem_signed;
        end
        s4_next.cmd     = s3_reg.cmd;
        s4_next.neg_a   = s3_reg.neg_a;
        s4_next.am      = s3_reg.am;
        s4_next.wrapped = wrapped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s3_stall)
            begin
                s3_valid_reg <= up_valid;
            end
            if (!s4_stall)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s3_stall && up_valid)
        begin
            s3_reg <= s3_next;
        end
        if (!s4_stall && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign dn_valid = s4_valid_reg;
    assign dn_data  = s4_reg;

endmodule

// File: rtl/core/smao_turn.sv
// turn stages: shortest steering move and the new continuous heading
module smao_turn
    import smao_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        steer_pol,
    input  logic        up_valid,
    input  wrap_out_t   up_data,
    output logic        up_stall,
    output logic        dn_valid,
    output turn_out_t   dn_data,
    input  logic        dn_stall
);

    logic        s5_valid_reg;
    turn_s5_t    s5_reg;
    turn_s5_t    s5_next;
    logic        s5_stall;
    logic        s6_valid_reg;
    turn_out_t   s6_reg;
    turn_out_t   s6_next;
    logic        s6_stall;

    logic signed [17:0] diff;
    logic signed [17:0] back;
    logic signed [39:0] heading_a;
    logic signed [40:0] heading_f;

    assign s5_stall = s5_valid_reg & s6_stall;
    assign s6_stall = s6_valid_reg & dn_stall;
    assign up_stall = s5_stall;

    // stage 5: pick the move of at most a quarter turn when the difference is within 450 degrees
    always_comb
    begin
        diff = 18'(up_data.cmd.heading) - 18'(up_data.wrapped);
        back = diff + DEG180;
        s5_next.cmd   = up_data.cmd;
        s5_next.neg_a = up_data.neg_a;
        s5_next.am    = up_data.am;
        s5_next.rev   = 1'b0;
        priority if (diff >= -DEG90 && diff <= DEG90)
        begin
            s5_next.delta = diff;
        end
        else if (diff >= DEG270 && diff <= DEG450)
        begin
            s5_next.delta = diff - DEG360;
        end
        else if (diff >= -DEG450 && diff <= -DEG270)
        begin
            s5_next.delta = diff + DEG360;
        end
        else
        begin
            // target behind the wheel: flip the drive
            s5_next.delta = (back > DEG90) ? back - DEG360 : back;
            s5_next.rev   = 1'b1;
        end
    end

    // stage 6: add the move to the continuous heading
    always_comb
    begin
        heading_a = s5_reg.neg_a ? -$signed({1'b0, s5_reg.am}) : $signed({1'b0, s5_reg.am});
        heading_f = 41'(heading_a) + 41'(s5_reg.delta);
        s6_next.cmd   = s5_reg.cmd;
        s6_next.rev   = s5_reg.rev;
        s6_next.f_neg = heading_f[40] ^ steer_pol;
        s6_next.fm    = heading_f[40] ? 40'(-heading_f) : heading_f[39:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s5_stall)
            begin
                s5_valid_reg <= up_valid;
            end
            if (!s6_stall)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s5_stall && up_valid)
        begin
            s5_reg <= s5_next;
        end
        if (!s6_stall && s5_valid_reg)
        begin
            s6_reg <= s6_next;
        end
    end

    assign dn_valid = s6_valid_reg;
    assign dn_data  = s6_reg;

endmodule

// File: rtl/core/smao_scale.sv
// output stages: heading to encoder counts, saturation, output register
module smao_scale
    import smao_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] counts_per_angle,
    input  logic        up_valid,
    input  turn_out_t   up_data,
    output logic        up_stall,
    output logic        dn_valid,
    output out_item_t   dn_data,
    input  logic        dn_stall
);

    logic        s7_valid_reg;
    scale_s7_t   s7_reg;
    scale_s7_t   s7_next;
    logic        s7_stall;
    logic        s8_valid_reg;
    out_item_t   s8_reg;
    out_item_t   s8_next;
    logic        s8_stall;

    logic [47:0] lo_prod;
    logic [56:0] q_sum;

    assign s7_stall = s7_valid_reg & s8_stall;
    assign s8_stall = s8_valid_reg & dn_stall;
    assign up_stall = s7_stall;

    // stage 7: upper and lower partial products
    always_comb
    begin
        lo_prod       = 48'(up_data.fm[15:0]) * 48'(counts_per_angle);
        s7_next.cmd   = up_data.cmd;
        s7_next.rev   = up_data.rev;
        s7_next.f_neg = up_data.f_neg;
        s7_next.qhi   = 56'(up_data.fm[39:16]) * 56'(counts_per_angle);
        s7_next.qlo   = lo_prod[47:16];
    end

    // stage 8: sum, saturate, blank rejected transactions
    always_comb
    begin
        q_sum = 57'(s7_reg.qhi) + 57'(s7_reg.qlo);
        if (s7_reg.cmd.rej)
        begin
            s8_next.wheel = 2'd0;
            s8_next.enc   = 32'sd0;
            s8_next.erpm  = 32'sd0;
            s8_next.rev   = 1'b0;
            s8_next.rej   = 1'b1;
        end
        else
        begin
            s8_next.wheel = s7_reg.cmd.wheel;
            s8_next.enc   = sat32(s7_reg.f_neg, q_sum);
            s8_next.erpm  = sat32(s7_reg.cmd.spd_neg ^ s7_reg.rev, 57'(s7_reg.cmd.em));
            s8_next.rev   = s7_reg.rev;
            s8_next.rej   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s7_stall)
            begin
                s7_valid_reg <= up_valid;
            end
            if (!s8_stall)
            begin
                s8_valid_reg <= s7_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s7_stall && up_valid)
        begin
            s7_reg <= s7_next;
        end
        if (!s8_stall && s7_valid_reg)
        begin
            s8_reg <= s8_next;
        end
    end

    assign dn_valid = s8_valid_reg;
    assign dn_data  = s8_reg;

endmodule

// File: rtl/core/swerve_module_angle_optimizer.sv
// top level of the swerve module angle optimiser
//
//  channel | direction | handshake            | payload
//  in      | to block  | in_valid, in_stall   | wheel_select, target_speed, target_heading,
//          |           |                      | encoder_total
//  out     | from block| out_valid, out_stall | wheel_out, encoder_target, drive_erpm,
//          |           |                      | drive_reversed, rejected
//  cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
//  one transaction per cycle when no stall holds the pipe; there are eight pipe stages
//  (two scaling multiplies, mod 45 fold, quotient, wrap, turn select, heading add,
//  encoder partial products, sum and saturation into the output register)
//  rst_n clears all stage valid bits and loads the register reset values at once
//  each stage holds while it is full and the stage after it stalls, so empty stages
//  keep filling behind a stalled output and in_stall rises only when the pipe is full
module swerve_module_angle_optimizer
    import smao_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         wheel_select,
    input  logic signed [15:0] target_speed,
    input  logic signed [15:0] target_heading,
    input  logic signed [31:0] encoder_total,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         wheel_out,
    output logic signed [31:0] encoder_target,
    output logic signed [31:0] drive_erpm,
    output logic               drive_reversed,
    output logic               rejected
);

`include "assert_macros.svh"

    logic        steer_pol_reg;
    logic [31:0] apc_reg;
    logic [31:0] cpa_reg;
    logic [31:0] eps_reg;

    in_item_t    in_item;
    logic        front_valid;
    front_out_t  front_data;
    logic        front_stall;
    logic        wrap_valid;
    wrap_out_t   wrap_data;
    logic        wrap_stall;
    logic        turn_valid;
    turn_out_t   turn_data;
    logic        turn_stall;
    out_item_t   out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_pol_reg <= 1'b0;
            apc_reg       <= APC_RESET;
            cpa_reg       <= CPA_RESET;
            eps_reg       <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_STEER_POL:        steer_pol_reg <= cfg_data[0];
                REG_ANGLE_PER_COUNT:  apc_reg       <= cfg_data;
                REG_COUNTS_PER_ANGLE: cpa_reg       <= cfg_data;
                REG_ERPM_PER_SPEED:   eps_reg       <= cfg_data;
                default:              steer_pol_reg <= steer_pol_reg;
            endcase
        end
    end

    assign in_item.wheel   = wheel_select;
    assign in_item.speed   = target_speed;
    assign in_item.heading = target_heading;
    assign in_item.count   = encoder_total;

    smao_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .steer_pol       (steer_pol_reg),
        .angle_per_count (apc_reg),
        .erpm_per_speed  (eps_reg),
        .up_valid        (in_valid),
        .up_data         (in_item),
        .up_stall        (in_stall),
        .dn_valid        (front_valid),
        .dn_data         (front_data),
        .dn_stall        (front_stall)
    );

    smao_wrap u_wrap (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_data  (front_data),
        .up_stall (front_stall),
        .dn_valid (wrap_valid),
        .dn_data  (wrap_data),
        .dn_stall (wrap_stall)
    );

    smao_turn u_turn (
        .clk       (clk),
        .rst_n     (rst_n),
        .steer_pol (steer_pol_reg),
        .up_valid  (wrap_valid),
        .up_data   (wrap_data),
        .up_stall  (wrap_stall),
        .dn_valid  (turn_valid),
        .dn_data   (turn_data),
        .dn_stall  (turn_stall)
    );

    smao_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .counts_per_angle (cpa_reg),
        .up_valid         (turn_valid),
        .up_data          (turn_data),
        .up_stall         (turn_stall),
        .dn_valid         (out_valid),
        .dn_data          (out_item),
        .dn_stall         (out_stall)
    );

    assign wheel_out      = out_item.wheel;
    assign encoder_target = out_item.enc;
    assign drive_erpm     = out_item.erpm;
    assign drive_reversed = out_item.rev;
    assign rejected       = out_item.rej;

    // a rejected transaction carries nothing else
    `SMAO_ASSERT(a_rej_blank, clk, rst_n, out_valid && rejected |-> wheel_out == 2'd0 && encoder_target == 32'sd0 && drive_erpm == 32'sd0 && !drive_reversed, "rejected result has non-zero fields")
    // accepted results only for wheels that exist
    `SMAO_ASSERT(a_wheel_range, clk, rst_n, out_valid && !rejected |-> wheel_out < 2'(WHEEL_COUNT), "wheel index out of range was not rejected")
    // a draining output frees every stage behind it
    `SMAO_ASSERT(a_no_false_stall, clk, rst_n, !(out_valid && out_stall) |-> !in_stall, "input stalled while output drains")
    // nothing leaves the pipe straight out of reset
    `SMAO_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

// File: test/swerve_module_angle_optimizer_test.sv
// self-checking testbench for the swerve module angle optimiser
module swerve_module_angle_optimizer_test
    import smao_pkg::*;
();

    localparam int PIPE_LATENCY   = 8;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT    = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int REPORT_LIMIT   = 10;

    class steer_scoreboard;
        logic        steer_neg;
        logic [31:0] angle_per_count;
        logic [31:0] counts_per_angle;
        logic [31:0] erpm_per_speed;
        out_item_t   expected_states[$];
        int          failures;
        int          reported;

        function new();
            steer_neg        = 1'b0;
            angle_per_count  = APC_RESET;
            counts_per_angle = CPA_RESET;
            erpm_per_speed   = EPS_RESET;
            failures         = 0;
            reported         = 0;
        endfunction

        function void set_reg(input reg_index_t idx, input logic [31:0] val);
            case (idx)
                REG_STEER_POL:        steer_neg = val[0];
                REG_ANGLE_PER_COUNT:  angle_per_count = val;
                REG_COUNTS_PER_ANGLE: counts_per_angle = val;
                REG_ERPM_PER_SPEED:   erpm_per_speed = val;
                default: ;
            endcase
        endfunction

        function longint abs_arc(input longint x);
            return (x < 0) ? -x : x;
        endfunction

        function logic [31:0] clamp_s32(input logic neg, input logic [63:0] mag);
            if (neg)
            begin
                return (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
            end
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        function out_item_t predict_module_state(input in_item_t c);
            out_item_t   r;
            longint      cnt, spd, ang, wrapped, diff, delta, fin;
            logic [63:0] cnt_mag, ang_mag, fin_mag, enc_mag, spd_mag, erpm_mag;
            logic        rev;
            r = '0;
            if (c.wheel >= WHEEL_COUNT)
            begin
                r.rej = 1'b1;
                return r;
            end
            // continuous heading from the multi-turn count
            cnt     = $signed(c.count);
            cnt_mag = (cnt < 0) ? -cnt : cnt;
            ang_mag = (cnt_mag * angle_per_count) >> 24;
            ang     = $signed(ang_mag);
            if ((cnt < 0) != steer_neg)
            begin
                ang = -ang;
            end
            // wrap into (-180, 180]
            wrapped = ang % DEG360;
            if (wrapped > DEG180)
            begin
                wrapped -= DEG360;
            end
            else if (wrapped <= -DEG180)
            begin
                wrapped += DEG360;
            end
            // shortest turn, flipping the drive when the target is behind
            diff = $signed(c.heading) - wrapped;
            rev  = 1'b0;
            if (abs_arc(diff) <= DEG90)
            begin
                delta = diff;
            end
            else if (abs_arc(diff - DEG360) <= DEG90)
            begin
                delta = diff - DEG360;
            end
            else if (abs_arc(diff + DEG360) <= DEG90)
            begin
                delta = diff + DEG360;
            end
            else
            begin
                delta = diff + DEG180;
                if (delta > DEG90)
                begin
                    delta -= DEG360;
                end
                rev = 1'b1;
            end
            fin      = ang + delta;
            fin_mag  = (fin < 0) ? -fin : fin;
            enc_mag  = (fin_mag >> 16) * counts_per_angle
                     + (((fin_mag & 64'hFFFF) * counts_per_angle) >> 16);
            spd      = $signed(c.speed);
            spd_mag  = (spd < 0) ? -spd : spd;
            erpm_mag = (spd_mag * erpm_per_speed) >> 16;
            r.wheel  = c.wheel;
            r.enc    = clamp_s32((fin < 0) != steer_neg, enc_mag);
            r.erpm   = clamp_s32((spd < 0) != rev, erpm_mag);
            r.rev    = rev;
            return r;
        endfunction

        function void note_input(input in_item_t c);
            expected_states.push_back(predict_module_state(c));
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_states.size() == 0)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    $display("unexpected result: wheel %0d enc %0d erpm %0d rev %0b rej %0b",
                             got.wheel, got.enc, got.erpm, got.rev, got.rej);
                end
                reported++;
                return;
            end
            want = expected_states.pop_front();
            if (got.wheel !== want.wheel || got.enc !== want.enc || got.erpm !== want.erpm
                || got.rev !== want.rev || got.rej !== want.rej)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    $display("mismatch: expected wheel %0d enc %0d erpm %0d rev %0b rej %0b",
                             want.wheel, want.enc, want.erpm, want.rev, want.rej);
                    $display("          actual   wheel %0d enc %0d erpm %0d rev %0b rej %0b",
                             got.wheel, got.enc, got.erpm, got.rev, got.rej);
                end
                reported++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         wheel_select;
    logic signed [15:0] target_speed;
    logic signed [15:0] target_heading;
    logic signed [31:0] encoder_total;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         wheel_out;
    logic signed [31:0] encoder_target;
    logic signed [31:0] drive_erpm;
    logic               drive_reversed;
    logic               rejected;

    steer_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    swerve_module_angle_optimizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .wheel_select   (wheel_select),
        .target_speed   (target_speed),
        .target_heading (target_heading),
        .encoder_total  (encoder_total),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .wheel_out      (wheel_out),
        .encoder_target (encoder_target),
        .drive_erpm     (drive_erpm),
        .drive_reversed (drive_reversed),
        .rejected       (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_input(in_item_t'({wheel_select, target_speed, target_heading,
                                          encoder_total}));
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_item_t'({wheel_out, encoder_target, drive_erpm,
                                             drive_reversed, rejected}));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** swerve_module_angle_optimizer: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_cmd(input logic [1:0] wheel, input logic signed [15:0] speed,
                            input logic signed [15:0] heading,
                            input logic signed [31:0] count);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        wheel_select   <= wheel;
        target_speed   <= speed;
        target_heading <= heading;
        encoder_total  <= count;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.expected_states.size() != 0);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic pol, input logic [31:0] apc,
                                 input logic [31:0] cpa, input logic [31:0] eps);
        write_reg(REG_STEER_POL, {31'd0, pol});
        write_reg(REG_ANGLE_PER_COUNT, apc);
        write_reg(REG_COUNTS_PER_ANGLE, cpa);
        write_reg(REG_ERPM_PER_SPEED, eps);
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t random_cmd();
        in_item_t    c;
        int unsigned pick;
        int          edges[14] = '{5760, -5760, 5761, -5761, 11520, -11520, 11519, -11519,
                                   17280, -17280, 17281, -17281, 23040, -23040};
        c.wheel = 2'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 10)
            c.speed = 16'sh8000;
        else if (pick < 20)
            c.speed = 16'sh7FFF;
        else if (pick < 25)
            c.speed = '0;
        else
            c.speed = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 60)
            c.heading = 16'($urandom_range(46080) - 23040);
        else if (pick < 75)
            c.heading = 16'($urandom);
        else
            c.heading = 16'(edges[$urandom_range(13)]);
        pick = $urandom_range(99);
        if (pick < 35)
            c.count = $urandom;
        else if (pick < 45)
            c.count = ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (pick < 70)
            c.count = $urandom_range(200000) - 100000;
        else
            // at one unit per count this puts the turn right on a branch edge
            c.count = $signed(c.heading) - edges[$urandom_range(13)];
        return c;
    endfunction

    initial
    begin
        in_item_t c;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_STEER_POL;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        wheel_select   <= '0;
        target_speed   <= '0;
        target_heading <= '0;
        encoder_total  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset setting
        send_cmd(0, 0, 0, 0);
        send_cmd(1, 32767, 23040, 2147483647);
        send_cmd(2, -32768, -23040, 32'sh8000_0000);
        send_cmd(3, 1234, 100, 5000);
        send_cmd(3, -32768, -23040, -1);
        send_cmd(0, 1000, 11520, 0);
        send_cmd(1, -1000, 5760, 0);
        send_cmd(2, 500, 5761, 0);
        send_cmd(0, 500, -5760, 0);
        send_cmd(1, 500, -5761, 0);
        send_cmd(2, 100, 17280, 0);
        send_cmd(0, 100, -17280, 0);
        send_cmd(1, 100, 17281, 0);
        send_cmd(0, 100, 32767, 0);
        send_cmd(1, 100, -32768, 0);
        send_cmd(2, -1, 0, -1);
        send_cmd(0, 1, 0, 1);
        send_cmd(1, 32767, -11520, 2147483647);
        send_cmd(2, -32768, 11519, 32'sh8000_0000);
        send_cmd(0, 0, 23040, 123456789);
        // heading exactly on the wrap boundary, from both sides
        send_cmd(1, 200, 0, 147456);
        send_cmd(2, 200, 0, -147456);
        send_cmd(0, 200, 0, 294912);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_pipe();
            case (phase)
                1: apply_setting(1'b1, 32'h0100_0000, 32'h0001_0000, 32'h0001_0000);
                2: apply_setting(1'b0, 32'h0100_0000, CPA_RESET, EPS_RESET);
                3: apply_setting(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                4: apply_setting(1'b0, 32'd0, 32'd0, 32'd0);
                5: apply_setting(1'($urandom_range(1)), $urandom, $urandom, $urandom);
                6: apply_setting(1'b1, APC_RESET, CPA_RESET, EPS_RESET);
                7: apply_setting(1'b0, 32'd1, 32'hFFFF_FFFF, 32'd1);
                default: ;
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            // fill the pipe against a held output
            if (phase % 4 == 0)
            begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                c = random_cmd();
                send_cmd(c.wheel, c.speed, c.heading, c.count);
            end
        end
        drain_pipe();

        if (sb.failures == 0 && sb.expected_states.size() == 0)
        begin
            $display("** swerve_module_angle_optimizer: PASSED **");
        end
        else
        begin
            $display("** swerve_module_angle_optimizer: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/smao_pkg.sv
rtl/core/smao_front.sv
rtl/core/smao_wrap.sv
rtl/core/smao_turn.sv
rtl/core/smao_scale.sv
rtl/core/swerve_module_angle_optimizer.sv
test/swerve_module_angle_optimizer_test.sv
